/* rtl/dtp_pkg.sv */
`default_nettype none

package dtp_pkg;

  // Trie geometry
  localparam int NODES    = 4096;
  localparam int ALPHABET = 10;

  localparam int NodeW   = $clog2(NODES);
  localparam int CountW  = NodeW + 1;
  localparam int DigitW  = 4;
  localparam int DigIdxW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int ReqW    = 2;

  // Request kinds
  localparam logic [ReqW-1:0] ReqInsert = 2'd0;
  localparam logic [ReqW-1:0] ReqQuery  = 2'd1;
  localparam logic [ReqW-1:0] ReqClear  = 2'd2;
  localparam logic [ReqW-1:0] ReqUnused = 2'd3;

  // Result kinds
  localparam logic OpInsert = 1'b0;
  localparam logic OpQuery  = 1'b1;

  typedef logic [NodeW-1:0]  node_t;
  typedef logic [CountW-1:0] count_t;
  typedef node_t [ALPHABET-1:0] row_t;

  // Write command to the node store
  typedef struct packed {
    logic  row_we;
    node_t row_addr;
    row_t  row_data;
    logic  mark_we;
    node_t mark_addr;
    logic  mark_data;
  } store_wr_t;

endpackage

`default_nettype wire

/* rtl/dtp_if.sv */
`default_nettype none

interface dtp_req_if;
  logic                     valid;
  logic                     ready;
  logic [dtp_pkg::ReqW-1:0] req_type;
  logic [dtp_pkg::DigitW-1:0] digit;
  logic                     last;

  modport source (output valid, req_type, digit, last, input ready);
  modport sink   (input valid, req_type, digit, last, output ready);
endinterface

interface dtp_rsp_if;
  logic valid;
  logic ready;
  logic op_kind;
  logic prefix_found;
  logic overflow;

  modport source (output valid, op_kind, prefix_found, overflow, input ready);
  modport sink   (input valid, op_kind, prefix_found, overflow, output ready);
endinterface

`default_nettype wire

/* rtl/dtp_store.sv */
`default_nettype none

// Node store: one child row and one end mark per node, registered read.
module dtp_store (
  input  wire                 clk_i,
  input  dtp_pkg::node_t      rd_addr_i,
  input  dtp_pkg::store_wr_t  wr_i,
  output dtp_pkg::row_t       rd_row_o,
  output logic                rd_mark_o
);

  dtp_pkg::row_t row_mem  [dtp_pkg::NODES];
  logic          mark_mem [dtp_pkg::NODES];

  always_ff @(posedge clk_i) begin
    if (wr_i.row_we) begin
      row_mem[wr_i.row_addr] <= wr_i.row_data;
    end
    rd_row_o <= row_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.mark_we) begin
      mark_mem[wr_i.mark_addr] <= wr_i.mark_data;
    end
    rd_mark_o <= mark_mem[rd_addr_i];
  end

endmodule

`default_nettype wire

/* rtl/digit_trie_prefix_table_core.sv */
`default_nettype none

// Channel | Dir | Payload                            | Transaction
// req_i   | in  | req_type, digit, last              | one digit or a clear
// rsp_o   | out | op_kind, prefix_found, overflow    | one per finished number
//
// A digit is accepted in IDLE, then executed in EXEC on the row read at the cursor;
// an insert that allocates a node adds an ALLOC step that zeroes the new row.
// The registered store read and the single row write port of the store set this order.
// A clear goes back to INIT: it rewrites only the root row and root end mark and resets the node count.
// After reset the block zeroes the root row in INIT before it takes
// a transaction. Rows above the node count are never read, so no wider pass exists.
// A result waits in the output register; execute stalls only if it must
// produce a new result while the previous one has not been taken.
module digit_trie_prefix_table_core (
  input  wire        clk_i,
  input  wire        rst_ni,
  dtp_req_if.sink    req_i,
  dtp_rsp_if.source  rsp_o
);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_ALLOC
  } state_e;

  state_e                      state_q;
  dtp_pkg::node_t              cursor_q;
  dtp_pkg::count_t             count_q;
  logic                        hit_q;
  logic                        lost_q;
  logic                        full_q;
  // Cursor was reached by a query step whose end mark is not yet checked.
  logic                        pend_q;
  logic [dtp_pkg::ReqW-1:0]    req_q;
  logic [dtp_pkg::DigitW-1:0]  digit_q;
  logic                        last_q;
  logic                        out_valid_q;
  logic                        out_kind_q;
  logic                        out_found_q;
  logic                        out_ovf_q;

  dtp_pkg::row_t      rd_row;
  logic               rd_mark;
  dtp_pkg::store_wr_t wr;

  // Store reads the row at the cursor every cycle.
  dtp_store u_store (
    .clk_i     (clk_i),
    .rd_addr_i (cursor_q),
    .wr_i      (wr),
    .rd_row_o  (rd_row),
    .rd_mark_o (rd_mark)
  );

  // Execute-stage decode
  logic            req_fire;
  logic            out_free;
  logic            dig_ok;
  dtp_pkg::node_t  child;
  logic            child_nz;
  logic            hit_eff;
  logic            is_ins;
  logic            is_qry;
  logic            ins_active;
  logic            need_alloc;
  logic            room;
  logic            alloc;
  logic            full_n;
  dtp_pkg::node_t  new_node;
  dtp_pkg::node_t  ins_cursor;
  logic            q_active;
  logic            q_move;
  logic            exec_go;
  logic            rsp_load;

  assign req_fire = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    dig_ok     = {1'b0, digit_q} < (dtp_pkg::DigitW + 1)'(dtp_pkg::ALPHABET);
    child      = dig_ok ? rd_row[digit_q[dtp_pkg::DigIdxW-1:0]] : '0;
    child_nz   = (child != '0);
    // Resolve the pending end mark of the node the query moved to.
    hit_eff    = hit_q || (pend_q && rd_mark);
    is_ins     = (req_q == dtp_pkg::ReqInsert);
    is_qry     = (req_q == dtp_pkg::ReqQuery);
    ins_active = !full_q && dig_ok;
    need_alloc = ins_active && !child_nz;
    room       = (count_q + dtp_pkg::count_t'(1)) < dtp_pkg::count_t'(dtp_pkg::NODES);
    alloc      = is_ins && need_alloc && room;
    full_n     = full_q || (need_alloc && !room);
    new_node   = dtp_pkg::NodeW'(count_q + dtp_pkg::count_t'(1));
    if (alloc) begin
      ins_cursor = new_node;
    end else if (ins_active && child_nz) begin
      ins_cursor = child;
    end else begin
      ins_cursor = cursor_q;
    end
    q_active   = !hit_eff && !lost_q;
    q_move     = q_active && dig_ok && child_nz;
    // Hold execute while a new result has nowhere to go.
    exec_go    = !last_q || out_free;
    // Load the output register when a finished number leaves execute.
    rsp_load   = (state_q == S_EXEC) && exec_go && last_q;
  end

  // Store write commands
  always_comb begin
    wr           = '0;
    wr.row_addr  = cursor_q;
    wr.row_data  = '0;
    wr.mark_addr = cursor_q;
    case (state_q)
      S_INIT: begin
        wr.row_we    = 1'b1;
        wr.row_addr  = '0;
        wr.mark_we   = 1'b1;
        wr.mark_addr = '0;
        wr.mark_data = 1'b0;
      end
      S_EXEC: begin
        if (exec_go && alloc) begin
          wr.row_we   = 1'b1;
          wr.row_data = rd_row;
          wr.row_data[digit_q[dtp_pkg::DigIdxW-1:0]] = new_node;
        end else if (exec_go && is_ins && last_q && !full_n) begin
          wr.mark_we   = 1'b1;
          wr.mark_addr = ins_cursor;
          wr.mark_data = 1'b1;
        end
      end
      S_ALLOC: begin
        // Zero the fresh node; mark it if the number ends here.
        wr.row_we    = 1'b1;
        wr.mark_we   = 1'b1;
        wr.mark_data = last_q;
      end
      default: begin
        wr.row_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cursor_q    <= '0;
      count_q     <= '0;
      hit_q       <= 1'b0;
      lost_q      <= 1'b0;
      full_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind_q  <= 1'b0;
      out_found_q <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (rsp_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT: begin
          count_q  <= '0;
          cursor_q <= '0;
          hit_q    <= 1'b0;
          lost_q   <= 1'b0;
          full_q   <= 1'b0;
          pend_q   <= 1'b0;
          state_q  <= S_IDLE;
        end
        S_IDLE: begin
          if (req_fire) begin
            if (req_i.req_type == dtp_pkg::ReqClear) begin
              state_q <= S_INIT;
            end else if (req_i.req_type == dtp_pkg::ReqInsert ||
                         req_i.req_type == dtp_pkg::ReqQuery) begin
              state_q <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state_q <= alloc ? S_ALLOC : S_IDLE;
            if (last_q) begin
              out_kind_q  <= is_qry ? dtp_pkg::OpQuery : dtp_pkg::OpInsert;
              out_found_q <= is_qry && hit_eff && !lost_q;
              out_ovf_q   <= is_ins && full_n;
            end
            if (alloc) begin
              // Advance into the new node; if the number ends here, the walk resets after it is zeroed.
              count_q  <= count_q + dtp_pkg::count_t'(1);
              cursor_q <= new_node;
              full_q   <= full_n;
              hit_q    <= hit_eff;
              pend_q   <= 1'b0;
            end else if (last_q) begin
              cursor_q <= '0;
              hit_q    <= 1'b0;
              lost_q   <= 1'b0;
              full_q   <= 1'b0;
              pend_q   <= 1'b0;
            end else if (is_ins) begin
              cursor_q <= ins_cursor;
              full_q   <= full_n;
              hit_q    <= hit_eff;
              pend_q   <= 1'b0;
            end else begin
              hit_q    <= hit_eff;
              lost_q   <= lost_q || (q_active && !q_move);
              pend_q   <= q_move;
              if (q_move) begin
                cursor_q <= child;
              end
            end
          end
        end
        S_ALLOC: begin
          state_q <= S_IDLE;
          if (last_q) begin
            cursor_q <= '0;
            hit_q    <= 1'b0;
            lost_q   <= 1'b0;
            full_q   <= 1'b0;
            pend_q   <= 1'b0;
          end
        end
        default: begin
          state_q <= S_INIT;
        end
      endcase
    end
  end

  // Capture the transaction payload.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q   <= req_i.req_type;
      digit_q <= req_i.digit;
      last_q  <= req_i.last;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.op_kind      = out_kind_q;
  assign rsp_o.prefix_found = out_found_q;
  assign rsp_o.overflow     = out_ovf_q;

  // The cursor only ever sits on an allocated node.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cursor_q} <= count_q)
    else $error("cursor beyond allocated nodes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < dtp_pkg::count_t'(dtp_pkg::NODES))
    else $error("node count overran the table");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC) |-> (cursor_q == count_q[dtp_pkg::NodeW-1:0]))
    else $error("zeroing a row that is not the newest node");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.req_type == dtp_pkg::ReqClear) |=> (state_q == S_INIT))
    else $error("clear did not rewrite the root");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_EXEC))
    else $error("result raised outside execute");

endmodule

`default_nettype wire

/* bench/tb_digit_trie_prefix_table_core.sv */
`default_nettype none

module tb_digit_trie_prefix_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dtp_pkg::*;

  // One finished number as the block reports it.
  typedef struct packed {
    logic op_kind;
    logic prefix_found;
    logic overflow;
  } verdict_t;

  // Mirror of the node store plus the queue of verdicts still owed by the block.
  class trie_checker;
    node_t       kids [int];      // sparse child table, keyed by node*ALPHABET+digit
    bit          marked [NODES];  // end-of-number marks
    count_t      used;            // allocated non-root nodes
    node_t       cur;             // walk position
    bit          hit;
    bit          lost;
    bit          full;
    verdict_t    due [$];
    int unsigned bad;

    function new();
      bad = 0;
      wipe();
    endfunction

    function void restart_walk();
      cur  = '0;
      hit  = 1'b0;
      lost = 1'b0;
      full = 1'b0;
    endfunction

    function void wipe();
      kids.delete();
      marked = '{default: 1'b0};
      used   = '0;
      restart_walk();
    endfunction

    function node_t child_of(node_t n, logic [DigitW-1:0] dg);
      int key;
      key = int'(n) * ALPHABET + int'(dg);
      return kids.exists(key) ? kids[key] : node_t'(0);
    endfunction

    // Advance the mirror by one accepted transaction; queue the verdict it causes.
    function void take_digit(logic [ReqW-1:0] rt, logic [DigitW-1:0] dg, logic lt);
      node_t    nxt;
      verdict_t v;
      case (rt)
        ReqClear: begin
          wipe();
        end
        ReqInsert: begin
          if (!full && int'(dg) < ALPHABET) begin
            nxt = child_of(cur, dg);
            if (nxt == '0) begin
              if (int'(used) + 1 >= NODES) begin
                full = 1'b1;
              end else begin
                used++;
                nxt = used[NodeW-1:0];
                kids[int'(cur) * ALPHABET + int'(dg)] = nxt;
              end
            end
            if (!full) cur = nxt;
          end
          if (lt) begin
            if (!full) marked[cur] = 1'b1;
            v = '{OpInsert, 1'b0, full};
            due.push_back(v);
            restart_walk();
          end
        end
        ReqQuery: begin
          if (!lt) begin
            if (!hit && !lost) begin
              if (int'(dg) >= ALPHABET) begin
                lost = 1'b1;
              end else begin
                nxt = child_of(cur, dg);
                if (nxt == '0) begin
                  lost = 1'b1;
                end else begin
                  cur = nxt;
                  if (marked[nxt]) hit = 1'b1;
                end
              end
            end
          end else begin
            v = '{OpQuery, hit && !lost, 1'b0};
            due.push_back(v);
            restart_walk();
          end
        end
        default: ;
      endcase
    endfunction

    function void match_verdict(logic op, logic pf, logic ov);
      verdict_t want;
      if (due.size() == 0) begin
        bad++;
        if (bad <= 10)
          $display("%t unexpected result op_kind=%b prefix_found=%b overflow=%b",
                   $realtime, op, pf, ov);
        return;
      end
      want = due.pop_front();
      if (op !== want.op_kind || pf !== want.prefix_found || ov !== want.overflow) begin
        bad++;
        if (bad <= 10)
          $display("%t mismatch: op_kind %b/%b prefix_found %b/%b overflow %b/%b (exp/act)",
                   $realtime, want.op_kind, op, want.prefix_found, pf,
                   want.overflow, ov);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  dtp_req_if req_if ();
  dtp_rsp_if rsp_if ();

  digit_trie_prefix_table_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  trie_checker board;

  // Sender knobs and number buffers.
  bit          gaps_on;
  bit          hold_off_req;
  int          items_sent;
  logic [3:0]  num_buf [48];
  bit          kind_buf [48];
  logic [3:0]  saved_num [64][48];
  int          saved_len [64];
  int          saved_n;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Sample both channels at the edge: retire results first, then note the new digit.
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready)
        board.match_verdict(rsp_if.op_kind, rsp_if.prefix_found, rsp_if.overflow);
      if (req_if.valid && req_if.ready)
        board.take_digit(req_if.req_type, req_if.digit, req_if.last);
    end
  end

  // Result side: random back-pressure, calm stretches, and one long hold-off on request.
  initial begin
    int  hold_cnt;
    int  r;
    bit  calm;
    hold_cnt = 0;
    calm = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 299) == 0) calm = ~calm;
      if (hold_cnt > 0) begin
        rsp_if.ready <= 1'b0;
        hold_cnt--;
      end else if (hold_off_req) begin
        // Hold off long enough for the output register and the input to back up.
        hold_off_req = 1'b0;
        hold_cnt = 400;
        rsp_if.ready <= 1'b0;
      end else if (calm) begin
        rsp_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          rsp_if.ready <= 1'b1;
        end else begin
          rsp_if.ready <= 1'b0;
          r = $urandom_range(0, 99);
          if (r < 85)      hold_cnt = $urandom_range(0, 2);
          else if (r < 97) hold_cnt = $urandom_range(3, 11);
          else             hold_cnt = $urandom_range(29, 59);
        end
      end
    end
  end

  // Mostly short idle gaps, a few long ones; none at all while gaps_on is low.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Favor a few digits so numbers share paths; now and then leave the alphabet.
  function automatic logic [3:0] pick_digit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 4'($urandom_range(0, 3));
    if (r < 97) return 4'($urandom_range(0, 9));
    return 4'($urandom_range(0, 15));
  endfunction

  // Offer one transaction after an optional gap; return at the accepting edge.
  task automatic send_item(input logic [ReqW-1:0] rt, input logic [3:0] dg, input logic lt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= rt;
    req_if.digit    <= dg;
    req_if.last     <= lt;
    do @(posedge clk); while (!req_if.ready);
    if (rt != ReqUnused) items_sent++;
  endtask

  task automatic send_number(input logic [ReqW-1:0] rt, input int len);
    for (int i = 0; i < len; i++) send_item(rt, num_buf[i], i == len - 1);
  endtask

  // Drop valid and hold until every owed verdict has come back.
  task automatic wait_all_verdicts();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (board.due.size() != 0) @(posedge clk);
  endtask

  function automatic void random_number(int len);
    for (int i = 0; i < len; i++) num_buf[i] = pick_digit();
  endfunction

  function automatic void keep_number(int len);
    int slot;
    if (saved_n < 64) begin
      slot = saved_n;
      saved_n++;
    end else begin
      slot = $urandom_range(0, 63);
    end
    saved_len[slot] = len;
    for (int i = 0; i < len; i++) saved_num[slot][i] = num_buf[i];
  endfunction

  // Load a stored number, then append the given count of extra digits so it may have a stored prefix.
  function automatic int extend_saved(int extra);
    int k;
    int len;
    k = $urandom_range(0, saved_n - 1);
    len = saved_len[k];
    for (int i = 0; i < len; i++) num_buf[i] = saved_num[k][i];
    for (int i = 0; i < extra; i++) num_buf[len + i] = 4'($urandom_range(0, 9));
    return len + extra;
  endfunction

  initial begin
    int r;
    int len;
    int iter;
    int spin;
    board        = new();
    rst_n        = 1'b0;
    gaps_on      = 1'b1;
    hold_off_req = 1'b0;
    items_sent   = 0;
    saved_n      = 0;
    req_if.valid    = 1'b0;
    req_if.req_type = ReqInsert;
    req_if.digit    = '0;
    req_if.last     = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: stored prefix hit, digit extremes, out-of-alphabet digits in both
    // kinds, a root mark, mixed kinds in one number, the unused kind and clear.
    send_item(ReqInsert, 4'd1, 1'b0);
    send_item(ReqInsert, 4'd2, 1'b1);
    send_item(ReqQuery,  4'd1, 1'b0);
    send_item(ReqQuery,  4'd2, 1'b0);
    send_item(ReqQuery,  4'd3, 1'b1);
    send_item(ReqInsert, 4'd0, 1'b0);
    send_item(ReqInsert, 4'd9, 1'b1);
    send_item(ReqQuery,  4'd0, 1'b0);
    send_item(ReqQuery,  4'd9, 1'b0);
    send_item(ReqQuery,  4'd0, 1'b1);
    send_item(ReqInsert, 4'd15, 1'b0);
    send_item(ReqInsert, 4'd7, 1'b1);
    send_item(ReqQuery,  4'd15, 1'b0);
    send_item(ReqQuery,  4'd7, 1'b1);
    send_item(ReqQuery,  4'd7, 1'b0);
    send_item(ReqQuery,  4'd4, 1'b1);
    send_item(ReqInsert, 4'd15, 1'b1);
    send_item(ReqInsert, 4'd8, 1'b0);
    send_item(ReqQuery,  4'd1, 1'b1);
    send_item(ReqQuery,  4'd1, 1'b0);
    send_item(ReqInsert, 4'd2, 1'b1);
    send_item(ReqUnused, 4'd15, 1'b1);
    send_item(ReqClear,  4'd0, 1'b1);
    send_item(ReqQuery,  4'd1, 1'b0);
    send_item(ReqQuery,  4'd2, 1'b1);
    wait_all_verdicts();

    // Random traffic: well-formed numbers with random content, plus noise.
    iter = 0;
    while (items_sent < 1600) begin
      iter++;
      if (iter % 150 == 0) gaps_on = $urandom_range(0, 3) != 0;
      if (iter == 150) begin
        // Stall the result side while offering back-to-back queries.
        hold_off_req = 1'b1;
        gaps_on = 1'b0;
        for (int n = 0; n < 30; n++) begin
          random_number(2);
          send_number(ReqQuery, 2);
        end
        gaps_on = 1'b1;
      end
      if (iter == 300) wait_all_verdicts();
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_item(ReqClear, pick_digit(), 1'($urandom_range(0, 1)));
        saved_n = 0;
      end else if (r < 40) begin
        len = $urandom_range(1, 6);
        random_number(len);
        keep_number(len);
        send_number(ReqInsert, len);
      end else if (r < 70 && saved_n > 0) begin
        len = extend_saved($urandom_range(0, 3));
        send_number(ReqQuery, len);
      end else if (r < 88) begin
        len = $urandom_range(1, 6);
        random_number(len);
        send_number(ReqQuery, len);
      end else if (r < 94) begin
        len = $urandom_range(1, 6);
        random_number(len);
        for (int i = 0; i < len; i++) kind_buf[i] = 1'($urandom_range(0, 1));
        for (int i = 0; i < len; i++)
          send_item(kind_buf[i] ? ReqQuery : ReqInsert, num_buf[i], i == len - 1);
      end else if (r < 97) begin
        send_item(ReqUnused, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) num_buf[i] = 4'($urandom_range(0, 15));
        send_number($urandom_range(0, 1) ? ReqQuery : ReqInsert, len);
      end
    end

    // Drain: wait for owed verdicts with a bound, then let the pipeline settle.
    req_if.valid <= 1'b0;
    spin = 0;
    while (board.due.size() != 0 && spin < 200000) begin
      @(posedge clk);
      spin++;
    end
    repeat (30) @(posedge clk);
    if (board.due.size() != 0)
      $display("%0d results never arrived", board.due.size());
    if (board.bad == 0 && board.due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
